@@ rtl/luhn_digit_stream_checker_core_defines.svh @@
// ----------------------------------------------------------------------------
// Luhn digit stream checker: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef LUHN_DIGIT_STREAM_CHECKER_CORE_DEFINES_SVH
`define LUHN_DIGIT_STREAM_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define LUHN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LUHN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/luhn_pkg.sv @@
// ----------------------------------------------------------------------------
// Luhn digit stream checker package
// Shared constants, state type and mod-10 helpers.
// ----------------------------------------------------------------------------
package luhn_pkg;

  localparam int unsigned LenW    = 5;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [LenW-1:0]    COUNT_MAX      = 5'd31;
  localparam logic [LenW-1:0]    MIN_LEN_RESET  = 5'd16;
  localparam logic [LenW-1:0]    MAX_LEN_RESET  = 5'd19;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LENGTH = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH = 8'd1;
  localparam logic [7:0]         CHAR_ZERO      = 8'h30;
  localparam logic [7:0]         CHAR_NINE      = 8'h39;

  typedef struct packed {
    logic [3:0]      sum_even;  // sum assuming even total length
    logic [3:0]      sum_odd;   // sum assuming odd total length
    logic [LenW-1:0] count;     // characters seen, saturating
    logic            bad;       // a non-digit was seen
  } luhn_state_t;

  function automatic logic [3:0] add_mod10(input logic [3:0] s, input logic [3:0] v);
    logic [4:0] t;
    t = {1'b0, s} + {1'b0, v};
    if (t >= 5'd10) begin
      t = t - 5'd10;
    end
    return t[3:0];
  endfunction

  // 2d, less 9 when above 9
  function automatic logic [3:0] doubled(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      t = t - 5'd9;
    end
    return t[3:0];
  endfunction

endpackage

@@ rtl/luhn_step.sv @@
// ----------------------------------------------------------------------------
// Luhn step
// Folds one character into the running state and forms the verdict.
// ----------------------------------------------------------------------------
module luhn_step (
  input  luhn_pkg::luhn_state_t        state,
  input  logic [7:0]                   char_code,
  input  logic [luhn_pkg::LenW-1:0]    min_length,
  input  logic [luhn_pkg::LenW-1:0]    max_length,
  output luhn_pkg::luhn_state_t        state_next,
  output logic                         number_ok
);

  logic       char_is_num;
  logic [3:0] digit;
  logic [3:0] sum_sel;

  assign char_is_num = (char_code >= luhn_pkg::CHAR_ZERO) &&
                       (char_code <= luhn_pkg::CHAR_NINE);
  assign digit       = char_code[3:0];

  always_comb begin
    state_next = state;
    if (!char_is_num) begin
      state_next.bad = 1'b1;
    end else if (state.count < luhn_pkg::COUNT_MAX) begin
      // even position from the left doubles under the even-length guess
      if (!state.count[0]) begin
        state_next.sum_even = luhn_pkg::add_mod10(state.sum_even, luhn_pkg::doubled(digit));
        state_next.sum_odd  = luhn_pkg::add_mod10(state.sum_odd, digit);
      end else begin
        state_next.sum_even = luhn_pkg::add_mod10(state.sum_even, digit);
        state_next.sum_odd  = luhn_pkg::add_mod10(state.sum_odd, luhn_pkg::doubled(digit));
      end
    end
    if (state.count < luhn_pkg::COUNT_MAX) begin
      state_next.count = state.count + 5'd1;
    end
  end

  assign sum_sel   = state_next.count[0] ? state_next.sum_odd : state_next.sum_even;
  assign number_ok = (state_next.count >= min_length) && (state_next.count <= max_length) &&
                     !state_next.bad && (sum_sel == 4'd0);

endmodule

@@ rtl/luhn_digit_stream_checker_core.sv @@
// ----------------------------------------------------------------------------
// Luhn digit stream checker core
// Streams card-number characters and gives one mod-10 verdict per number.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata = char_code, s_tlast = last_char
// m_*      out  m_tvalid/m_tready  m_tdata[0] = number_ok
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (min/max length)
//
// One character per cycle unless a last char waits for queue room. A
// character is registered at the input and folded into the running sums
// from there; a last char's verdict is registered into the queue head or skid.
// Reset clears the running state and sets the limits to 16 and 19.
// A two-entry result queue lets the input keep moving while the sink stalls;
// s_tready drops only when both entries are full and a last char waits.
//
module luhn_digit_stream_checker_core (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] char_code
  input  logic                          s_tlast,   // last_char
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [0] number_ok, [7:1] zero
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [luhn_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [luhn_pkg::LenW-1:0]     cfg_data
);

  `include "luhn_digit_stream_checker_core_defines.svh"

  // configuration registers
  logic [luhn_pkg::LenW-1:0] min_length;
  logic [luhn_pkg::LenW-1:0] max_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= luhn_pkg::MIN_LEN_RESET;
      max_length <= luhn_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == luhn_pkg::CFG_MIN_LENGTH) begin
        min_length <= cfg_data;
      end
      if (cfg_index == luhn_pkg::CFG_MAX_LENGTH) begin
        max_length <= cfg_data;
      end
    end
  end

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       advance;
  logic       q_room;

  // a last char may move on only when the result queue has room
  assign advance  = in_valid && (!in_last || q_room);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // running state
  luhn_pkg::luhn_state_t state;
  luhn_pkg::luhn_state_t state_next;
  logic                  ok_next;

  luhn_step u_step (
    .state      (state),
    .char_code  (in_char),
    .min_length (min_length),
    .max_length (max_length),
    .state_next (state_next),
    .number_ok  (ok_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= in_last ? '0 : state_next;
    end
  end

  // result queue: head drives m_*, second entry is the skid
  logic push;
  logic pop;
  logic head_ok;
  logic q1_valid;
  logic q1_ok;

  assign push   = advance && in_last;
  assign pop    = m_tvalid && m_tready;
  assign q_room = !q1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      q1_valid <= 1'b0;
    end else if (pop) begin
      if (q1_valid) begin
        m_tvalid <= 1'b1;
        q1_valid <= push;
      end else begin
        m_tvalid <= push;
      end
    end else if (!m_tvalid) begin
      m_tvalid <= push;
    end else if (push) begin
      q1_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q1_valid) begin
        head_ok <= q1_ok;
        q1_ok   <= ok_next;
      end else begin
        head_ok <= ok_next;
      end
    end else if (!m_tvalid) begin
      head_ok <= ok_next;
    end else if (push) begin
      q1_ok <= ok_next;
    end
  end

  assign m_tdata = {7'd0, head_ok};

  // checks
  `LUHN_ASSERT_NOW(a_skid_behind_head, q1_valid, m_tvalid, "skid entry valid with empty head")
  `LUHN_ASSERT_NOW(a_sum_range, 1'b1, (state.sum_even <= 4'd9) && (state.sum_odd <= 4'd9),
    "running sum out of mod-10 range")
  `LUHN_ASSERT_NEXT(a_clear_after_last, push, state == '0, "state not cleared after last char")
  `LUHN_ASSERT_NOW(a_stall_cause, !s_tready, in_valid && in_last && q1_valid,
    "input stalled without a full result queue")

endmodule
